>>> sv/timed_event_scheduler_core_assert.svh
// Assertion macros for the timed event scheduler.
// Used by the top level only; no dependencies.
`ifndef TIMED_EVENT_SCHEDULER_CORE_ASSERT_SVH
`define TIMED_EVENT_SCHEDULER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TES_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TES_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TES_ASSERT(label, clk, rst, prop, msg)
`define TES_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

>>> sv/tes_pkg.sv
// Shared types and constants of the timed event scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tes_pkg;
  localparam logic [2:0] MODE_SCHED   = 3'd0;
  localparam logic [2:0] MODE_UNSCHED = 3'd1;
  localparam logic [2:0] MODE_REMOVE  = 3'd2;
  localparam logic [2:0] MODE_ADVANCE = 3'd3;
  localparam logic [2:0] MODE_CONSUME = 3'd4;
  localparam logic [2:0] MODE_IDLE    = 3'd5;
  localparam int IN_W  = 176;
  localparam int OUT_W = 240;

  // One stored event.
  typedef struct packed {
    logic [63:0] due;
    logic [31:0] order;
    logic [7:0]  ekind;
    logic [63:0] data;
  } slot_t;

  // One result beat.
  typedef struct packed {
    logic        last;
    logic        status;
    logic [31:0] idle_ticks;
    logic [31:0] down_count;
    logic [63:0] ticks_now;
    logic [31:0] lateness;
    logic [63:0] user_data_out;
    logic [7:0]  event_kind_out;
    logic        kind;
  } result_t;
endpackage
`default_nettype wire

>>> sv/tes_slot_ram.sv
// Event store memory: one write port, one registered read port.
// Depends on tes_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tes_slot_ram #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [AW-1:0]  waddr,
  input  wire tes_pkg::slot_t wdata,
  input  wire logic [AW-1:0]  raddr,
  output tes_pkg::slot_t      rdata
);
  import tes_pkg::*;
  slot_t mem [DEPTH];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sv/timed_event_scheduler_core.sv
// Timed event scheduler core: one item at a time, sequenced over the event store.
// Items are not overlapped: the next input beat is taken the cycle after the status beat is
// built. Unschedule, remove and advance scan the store, one entry read per cycle; output
// stalls only hold the fired and status beats.
// Reset (rst, synchronous): clears valid bits, counters and totals; store
// contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module timed_event_scheduler_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // mode[2:0], delay[34:3], event_kind[42:35], user_data[106:43],
  // slice_limit[137:107], tick_count[168:138], zero pad
  input  wire logic [tes_pkg::IN_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // event_kind_out[7:0], user_data_out[71:8], lateness[103:72], ticks_now[167:104],
  // down_count[199:168], idle_ticks[231:200], status[232], zero pad
  output logic [tes_pkg::OUT_W-1:0]      m_tdata,
  // kind[0]
  output logic                           m_tuser,
  output logic                           m_tlast
);
  import tes_pkg::*;
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_MATCH, S_FIRE, S_OUT} state_t;
  state_t state;

  logic [2:0]  mode;
  logic [7:0]  ek;
  logic [63:0] ud;
  logic [30:0] limit;

  logic [QUEUE_DEPTH-1:0] valid;
  logic [63:0] executed_total;
  logic [31:0] slice_len, down_counter, idle_total, next_order;

  logic [CW-1:0] rcnt;   // read address counter
  logic [AW-1:0] pcnt;   // entry index of data arriving this cycle
  logic          pv;     // read data valid
  logic          best_ok;
  logic [AW-1:0] best_i;
  slot_t         best;
  logic          status;

  logic          we;
  logic [AW-1:0] waddr;
  slot_t         wdata;
  slot_t         rdata;
  logic [AW-1:0] raddr;

  result_t res;
  logic    ovalid;

  logic in_go, fire_go, out_go, rd_issue, scanning;

  // Read address: walk the store while scanning, else entry zero.
  assign scanning = (state == S_SCAN) || (state == S_MATCH);
  assign raddr = (scanning && rcnt < CW'(QUEUE_DEPTH)) ? rcnt[AW-1:0] : '0;
  tes_slot_ram #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Current time and free slot search.
  logic [63:0] now_ticks;
  assign now_ticks = executed_total + {{32{slice_len[31]}}, slice_len}
                     - {{32{down_counter[31]}}, down_counter};
  logic          free_ok;
  logic [AW-1:0] free_i;
  always_comb begin
    free_ok = 1'b0;
    free_i  = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_ok = 1'b1;
        free_i  = AW'(i);
      end
    end
  end

  logic pvalid;
  assign pvalid = pv && valid[pcnt];
  logic better;
  assign better = !best_ok || rdata.due < best.due
                  || (rdata.due == best.due && rdata.order < best.order);

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = ovalid;
  assign m_tdata  = {7'd0, res[233:1]};
  assign m_tuser  = res.kind;
  assign m_tlast  = res.last;

  // Handshake and read-issue strobes.
  assign in_go   = s_tvalid && s_tready;
  assign fire_go = (state == S_FIRE) && best_ok && (best.due <= executed_total)
                   && (!ovalid || m_tready);
  assign out_go  = (state == S_OUT) && (!ovalid || m_tready);
  assign rd_issue = (in_go && (s_tdata[2:0] == MODE_UNSCHED || s_tdata[2:0] == MODE_REMOVE
                               || s_tdata[2:0] == MODE_ADVANCE))
                    || (scanning && rcnt < CW'(QUEUE_DEPTH)) || fire_go;

  always_comb begin
    we    = (state == S_IDLE) && s_tvalid && s_tready
            && s_tdata[2:0] == MODE_SCHED && free_ok;
    waddr = free_i;
    wdata.due   = now_ticks + {32'd0, s_tdata[34:3]};
    wdata.order = next_order;
    wdata.ekind = s_tdata[42:35];
    wdata.data  = s_tdata[106:43];
  end

  logic [63:0] gap;
  assign gap = best.due - executed_total;

  // Sequencer: accept, scan store, fire, report.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      executed_total <= '0;
      slice_len <= '0;
      down_counter <= '0;
      idle_total <= '0;
      next_order <= '0;
      ovalid <= 1'b0;
      pv <= 1'b0;
      rcnt <= '0;
      pcnt <= '0;
      best_ok <= 1'b0;
    end else begin
      ovalid <= fire_go || out_go || (ovalid && !m_tready);
      pv   <= rd_issue;
      pcnt <= raddr;
      case (state)
        S_IDLE: begin
          if (in_go) begin
            mode  <= s_tdata[2:0];
            ek    <= s_tdata[42:35];
            ud    <= s_tdata[106:43];
            limit <= s_tdata[137:107];
            status <= (s_tdata[2:0] == MODE_SCHED) && !free_ok;
            best_ok <= 1'b0;
            case (s_tdata[2:0])
              MODE_SCHED: begin
                if ($signed(down_counter) > $signed({1'b0, s_tdata[34:3]})) begin
                  slice_len <= slice_len - (down_counter - s_tdata[34:3]);
                  down_counter <= s_tdata[34:3];
                end
                if (free_ok) begin
                  valid[free_i] <= 1'b1;
                  next_order <= next_order + 32'd1;
                end
                state <= S_OUT;
              end
              MODE_UNSCHED, MODE_REMOVE: begin
                rcnt <= CW'(1);
                state <= S_MATCH;
              end
              MODE_ADVANCE: begin
                executed_total <= executed_total
                  + {{32{slice_len[31]}}, slice_len}
                  - {{32{down_counter[31]}}, down_counter};
                idle_total <= '0;
                slice_len <= {1'b0, s_tdata[137:107]};
                rcnt <= CW'(1);
                state <= S_SCAN;
              end
              MODE_CONSUME: begin
                down_counter <= down_counter - {1'b0, s_tdata[168:138]};
                state <= S_OUT;
              end
              MODE_IDLE: begin
                idle_total <= idle_total + down_counter;
                down_counter <= '0;
                state <= S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_MATCH: begin
          // Drop matching entries as their data arrives.
          if (pvalid && rdata.ekind == ek && (mode == MODE_REMOVE || rdata.data == ud)) begin
            valid[pcnt] <= 1'b0;
          end
          if (rcnt < CW'(QUEUE_DEPTH)) begin
            rcnt <= rcnt + CW'(1);
          end else if (!pv) begin
            state <= S_OUT;
          end
        end
        S_SCAN: begin
          // Track the earliest pending entry.
          if (pvalid && better) begin
            best_ok <= 1'b1;
            best <= rdata;
            best_i <= pcnt;
          end
          if (rcnt < CW'(QUEUE_DEPTH)) begin
            rcnt <= rcnt + CW'(1);
          end else if (!pv) begin
            state <= S_FIRE;
          end
        end
        S_FIRE: begin
          if (best_ok && best.due <= executed_total) begin
            if (fire_go) begin
              valid[best_i] <= 1'b0;
              res.kind <= 1'b1;
              res.event_kind_out <= best.ekind;
              res.user_data_out <= best.data;
              res.lateness <= (executed_total - best.due > 64'hFFFF_FFFF)
                              ? 32'hFFFF_FFFF : 32'(executed_total - best.due);
              res.ticks_now <= executed_total;
              res.down_count <= '0;
              res.idle_ticks <= '0;
              res.status <= 1'b0;
              res.last <= 1'b0;
              best_ok <= 1'b0;
              rcnt <= CW'(1);
              state <= S_SCAN;
            end
          end else begin
            if (best_ok && gap < {33'd0, limit}) begin
              slice_len <= gap[31:0];
              down_counter <= gap[31:0];
            end else begin
              down_counter <= slice_len;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_go) begin
            res.kind <= 1'b0;
            res.event_kind_out <= '0;
            res.user_data_out <= '0;
            res.lateness <= '0;
            res.ticks_now <= now_ticks;
            res.down_count <= down_counter;
            res.idle_ticks <= idle_total;
            res.status <= status;
            res.last <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "timed_event_scheduler_core_assert.svh"
  `TES_ASSERT(a_no_accept_busy, clk, rst, (s_tvalid && s_tready) |=> (state != S_IDLE), "busy after accept")
  `TES_ASSERT(a_hold_out, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "output changed while stalled")
  `TES_ASSERT(a_fire_not_last, clk, rst, (m_tvalid && m_tuser) |-> !m_tlast, "fired beat marked last")
endmodule
`default_nettype wire

>>> sim/timed_event_scheduler_core_checker.sv
// Checker for the timed event scheduler: predicts result beats from accepted input beats.
// Depends on tes_pkg for the mode codes and the bus widths.
`timescale 1ns / 1ps
module timed_event_scheduler_core_checker #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [tes_pkg::IN_W-1:0] s_tdata,
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [tes_pkg::OUT_W-1:0] m_tdata,
  input  logic                     m_tuser,
  input  logic                     m_tlast,
  output int                       fail_count,
  output int                       pending
);
  import tes_pkg::*;

  typedef struct {
    logic [255:0] bits;
    logic         last;
  } beat_t;

  // Shadow copy of the scheduler state
  logic        sh_valid [DEPTH];
  logic [63:0] sh_due   [DEPTH];
  logic [31:0] sh_order [DEPTH];
  logic [7:0]  sh_kind  [DEPTH];
  logic [63:0] sh_data  [DEPTH];
  logic [63:0] sh_exec;
  logic [31:0] sh_slice, sh_down, sh_idle, sh_next;

  beat_t expected_beats[$];

  // Result field layout, lowest bit up (kind from tuser, the rest from tdata)
  int    fld_lo [8] = '{0, 1, 9, 73, 105, 169, 201, 233};
  int    fld_w  [8] = '{1, 8, 64, 32, 64, 32, 32, 1};
  string fld_nm [8] = '{"kind", "event_kind_out", "user_data_out", "lateness",
                        "ticks_now", "down_count", "idle_ticks", "status"};

  assign pending = expected_beats.size();

  function automatic logic [63:0] sext(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] now_ticks();
    return sh_exec + sext(sh_slice) - sext(sh_down);
  endfunction

  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (!sh_valid[i]) continue;
      if (best < 0 || sh_due[i] < sh_due[best] ||
          (sh_due[i] == sh_due[best] && sh_order[i] < sh_order[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic logic [255:0] pack_result(input logic kd, input logic [7:0] ek,
      input logic [63:0] ud, input logic [31:0] late, input logic [63:0] tn,
      input logic [31:0] dc, input logic [31:0] idl, input logic st);
    logic [255:0] v;
    v = '0;
    v[0] = kd;
    v[8:1] = ek;
    v[72:9] = ud;
    v[104:73] = late;
    v[168:105] = tn;
    v[200:169] = dc;
    v[232:201] = idl;
    v[233] = st;
    return v;
  endfunction

  task automatic push_beat(input logic [255:0] b, input logic l);
    beat_t e;
    e.bits = b;
    e.last = l;
    expected_beats.push_back(e);
  endtask

  // Apply one input beat to the shadow state and queue its results
  task automatic predict_events(input logic [IN_W-1:0] d);
    logic [2:0]  md;
    logic [31:0] dly, lim, tk;
    logic [7:0]  ek;
    logic [63:0] ud, due, late, gap;
    logic        st;
    int          free_i, e;
    md  = d[2:0];
    dly = d[34:3];
    ek  = d[42:35];
    ud  = d[106:43];
    lim = {1'b0, d[137:107]};
    tk  = {1'b0, d[168:138]};
    st  = 1'b0;
    case (md)
      MODE_SCHED: begin
        due = now_ticks() + {32'd0, dly};
        if ($signed(sext(sh_down)) > $signed({32'd0, dly})) begin
          sh_slice = sh_slice - (sh_down - dly);
          sh_down  = dly;
        end
        free_i = -1;
        for (int i = 0; i < DEPTH; i++)
          if (!sh_valid[i] && free_i < 0) free_i = i;
        if (free_i < 0) begin
          st = 1'b1;
        end else begin
          sh_valid[free_i] = 1'b1;
          sh_due[free_i]   = due;
          sh_order[free_i] = sh_next;
          sh_kind[free_i]  = ek;
          sh_data[free_i]  = ud;
          sh_next++;
        end
      end
      MODE_UNSCHED, MODE_REMOVE: begin
        for (int i = 0; i < DEPTH; i++)
          if (sh_valid[i] && sh_kind[i] == ek && (md == MODE_REMOVE || sh_data[i] == ud))
            sh_valid[i] = 1'b0;
      end
      MODE_ADVANCE: begin
        sh_exec  = sh_exec + sext(sh_slice) - sext(sh_down);
        sh_idle  = '0;
        sh_slice = lim;
        forever begin
          e = earliest_slot();
          if (e < 0 || sh_due[e] > sh_exec) break;
          late = sh_exec - sh_due[e];
          if (late > 64'hFFFF_FFFF) late = 64'hFFFF_FFFF;
          sh_valid[e] = 1'b0;
          push_beat(pack_result(1'b1, sh_kind[e], sh_data[e], late[31:0], sh_exec,
                                '0, '0, 1'b0), 1'b0);
        end
        e = earliest_slot();
        if (e >= 0) begin
          gap = sh_due[e] - sh_exec;
          if (gap < {32'd0, lim}) sh_slice = gap[31:0];
        end
        sh_down = sh_slice;
      end
      MODE_CONSUME: sh_down = sh_down - tk;
      MODE_IDLE: begin
        sh_idle = sh_idle + sh_down;
        sh_down = '0;
      end
      default: ;
    endcase
    push_beat(pack_result(1'b0, '0, '0, '0, now_ticks(), sh_down, sh_idle, st), 1'b1);
  endtask

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin
    beat_t        e;
    logic [255:0] act, mask;
    int           nfail;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) sh_valid[i] <= 1'b0;
      sh_exec  <= '0;
      sh_slice <= '0;
      sh_down  <= '0;
      sh_idle  <= '0;
      sh_next  <= '0;
      fail_count <= 0;
    end else begin
      nfail = 0;
      if (s_tvalid && s_tready) predict_events(s_tdata);
      if (m_tvalid && m_tready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, m_tdata);
          nfail++;
        end else begin
          e = expected_beats.pop_front();
          act = '0;
          act[0] = m_tuser;
          act[233:1] = m_tdata[232:0];
          // only bits that the bus carries can be compared
          mask = '0;
          mask[233:0] = '1;
          for (int f = 0; f < 8; f++) begin
            if ((((e.bits ^ act) & mask) >> fld_lo[f]) & ((256'd1 << fld_w[f]) - 1)) begin
              $display("%0t: %s mismatch expected %h actual %h", $time, fld_nm[f],
                       (e.bits >> fld_lo[f]) & ((256'd1 << fld_w[f]) - 1),
                       (act >> fld_lo[f]) & ((256'd1 << fld_w[f]) - 1));
              nfail++;
            end
          end
          if (m_tlast !== e.last) begin
            $display("%0t: last mismatch expected %b actual %b", $time, e.last, m_tlast);
            nfail++;
          end
        end
      end
      fail_count <= fail_count + nfail;
    end
  end
endmodule

>>> sim/timed_event_scheduler_core_tb.sv
// Testbench top for the timed event scheduler: clock, reset, stimulus and verdict.
// Depends on tes_pkg, timed_event_scheduler_core and its checker.
`timescale 1ns / 1ps
module timed_event_scheduler_core_tb;
  import tes_pkg::*;

  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 260;

  logic             clk, rst;
  logic             s_tvalid, s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid, m_tready, m_tlast, m_tuser;
  logic [OUT_W-1:0] m_tdata;
  int               fail_count, pending;
  int               cycle_n, quiet_cycles;
  logic             no_idle;

  timed_event_scheduler_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  timed_event_scheduler_core_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Count cycles and keep one long window free of idling
  always @(posedge clk) cycle_n <= cycle_n + 1;
  assign no_idle = (cycle_n > 2000 && cycle_n < 4000);

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timed_event_scheduler_core verification failed");
      $finish;
    end
  end

  // Receiver: random back-pressure plus one long hold-off
  initial begin
    int hold;
    m_tready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (cycle_n == 600) hold = 500;
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_idle || ($urandom_range(99) >= 6);
      end
    end
  end

  function automatic logic [IN_W-1:0] pack_item(input logic [2:0] md, input logic [31:0] dly,
      input logic [7:0] ek, input logic [63:0] ud, input logic [30:0] lim,
      input logic [30:0] tk);
    return {7'd0, tk, lim, ud, ek, dly, md};
  endfunction

  // Offer one beat and hold it until accepted
  task automatic send_item(input logic [IN_W-1:0] d);
    while (!no_idle && $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [63:0] pool [4];
    logic [2:0]  md;
    logic [31:0] dly;
    logic [30:0] lim, tk;
    int          pick;
    cycle_n = 0;
    quiet_cycles = 0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    for (int i = 0; i < 4; i++) pool[i] = rand64();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, every mode, full store, spare modes
    send_item(pack_item(MODE_SCHED, 32'd0, 8'h00, 64'd0, '0, '0));
    send_item(pack_item(MODE_SCHED, 32'hFFFF_FFFF, 8'hFF, '1, '1, '1));
    send_item(pack_item(MODE_ADVANCE, 32'd0, 8'd0, 64'd0, 31'd0, 31'd0));
    send_item(pack_item(MODE_ADVANCE, '1, 8'd0, 64'd0, 31'h7FFF_FFFF, 31'd0));
    send_item(pack_item(MODE_CONSUME, 32'd0, 8'd0, 64'd0, 31'd0, 31'h7FFF_FFFF));
    send_item(pack_item(MODE_SCHED, 32'd5, 8'h11, pool[0], 31'd0, 31'd0));
    send_item(pack_item(MODE_UNSCHED, 32'd0, 8'h11, pool[0], 31'd0, 31'd0));
    send_item(pack_item(MODE_REMOVE, 32'd0, 8'hFF, 64'd0, 31'd0, 31'd0));
    send_item(pack_item(MODE_IDLE, 32'd0, 8'd0, 64'd0, 31'd0, 31'd0));
    send_item(pack_item(MODE_SPARE_LO, '1, 8'hFF, '1, '1, '1));
    send_item(pack_item(MODE_SPARE_HI, 32'd0, 8'd0, 64'd0, 31'd0, 31'd0));
    for (int i = 0; i < 17; i++)
      send_item(pack_item(MODE_SCHED, 32'd3, 8'(i), rand64(), 31'd0, 31'd0));
    send_item(pack_item(MODE_ADVANCE, 32'd0, 8'd0, 64'd0, 31'd100, 31'd0));
    send_item(pack_item(MODE_ADVANCE, 32'd0, 8'd0, 64'd0, 31'd100, 31'd0));

    // Random: mostly schedule and advance on a small set of kinds and data
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99);
      dly = ($urandom_range(9) == 0) ? $urandom : $urandom_range(60);
      lim = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(80));
      tk  = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(40));
      if (pick < 40) md = MODE_SCHED;
      else if (pick < 50) md = MODE_UNSCHED;
      else if (pick < 55) md = MODE_REMOVE;
      else if (pick < 75) md = MODE_ADVANCE;
      else if (pick < 88) md = MODE_CONSUME;
      else if (pick < 94) md = MODE_IDLE;
      else md = 3'($urandom_range(7));
      send_item(pack_item(md, dly, 8'($urandom_range(3)),
                          ($urandom_range(3) == 0) ? rand64() : pool[$urandom_range(3)],
                          lim, tk));
    end
    s_tvalid <= 1'b0;

    // Drain, then let the block settle
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("timed_event_scheduler_core verification clean");
    end else begin
      $display("timed_event_scheduler_core verification failed");
    end
    $finish;
  end
endmodule
